FILE: design/touch_canvas_line_plotter_unit_macros.svh
// Assertion macros shared by the checker of the touch canvas line plotter.
// No dependencies; the including file must provide signals named clock and reset.
`ifndef TOUCH_CANVAS_LINE_PLOTTER_UNIT_MACROS_SVH
`define TOUCH_CANVAS_LINE_PLOTTER_UNIT_MACROS_SVH

// Checked at every clock edge outside of reset.
`define TCLP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define TCLP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: design/tclp_pkg.sv
// Shared constants and controller/datapath interface types of the line plotter.
// No dependencies.
package tclp_pkg;

   localparam int COORD_W   = 7;
   localparam int FRAC_BITS = 12;
   localparam int QUO_W     = COORD_W + FRAC_BITS;
   localparam int ACC_W     = QUO_W + 3;
   localparam int DIV_CNT_W = 5;
   localparam int PAD_ORIGIN = 16;
   localparam int DEF_COLS  = 64;
   localparam int DEF_ROWS  = 64;

   localparam logic [1:0] KIND_PAINT = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_PEN   = 2'd2;

   localparam logic CMD_TOUCH  = 1'b0;
   localparam logic CMD_BUTTON = 1'b1;

   typedef struct packed {
      logic load;
      logic clr_step;
      logic stroke_clr;
      logic line_init;
      logic div_step;
      logic line_start;
      logic advance;
      logic rd_first;
      logic rd_line;
      logic paint_first;
      logic paint_line;
      logic emit_end;
      logic emit_pen;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic is_btn;
      logic toggle;
      logic in_pad;
      logic stroke;
      logic same_cell;
      logic div_done;
      logic at_end;
      logic plot_ok;
      logic differs;
      logic out_free;
   } dp_status_type;

endpackage

FILE: design/tclp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tclp_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/tclp_datapath.sv
// Datapath of the line plotter: pad mapping, serial divider, DDA stepper,
// canvas access and the result register. Depends on tclp_pkg.
module tclp_datapath import tclp_pkg::*; #(
   parameter int COLS = DEF_COLS,
   parameter int ROWS = DEF_ROWS,
   parameter int AW   = $clog2(COLS * ROWS)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_cmd,
   input  logic          req_touched,
   input  logic [7:0]    req_touch_x,
   input  logic [7:0]    req_touch_y,
   input  logic          req_button,
   input  logic          req_press,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   output logic          ram_wr_en,
   output logic [AW-1:0] ram_wr_addr,
   output logic          ram_wr_data,
   output logic          ram_rd_en,
   output logic [AW-1:0] ram_rd_addr,
   input  logic          ram_rd_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [1:0]    rsp_kind,
   output logic [5:0]    rsp_cell_x,
   output logic [5:0]    rsp_cell_y,
   output logic          rsp_pen_value,
   output logic          rsp_last_result
);

   localparam int DEPTH = COLS * ROWS;

   // Latched request.
   logic       cmd_ff, touched_ff, button_ff, press_ff;
   logic [7:0] tx_ff, ty_ff;

   // Architectural state.
   logic               pen_ff, stroke_ff;
   logic [COORD_W-1:0] last_col_ff, last_row_ff;

   // Line setup and divider.
   logic                 xmaj_ff, step_neg_ff, slope_neg_ff;
   logic [COORD_W-1:0]   c_ff, c_end_ff, minor0_ff, den_ff;
   logic [QUO_W-1:0]     num_ff, quo_ff;
   logic [COORD_W:0]     rem_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic signed [ACC_W-1:0] acc_ff, slope_ff;

   // Cell under test and clearing sweep.
   logic [COORD_W-1:0] px_ff, py_ff;
   logic [AW-1:0]      addr_ff, clr_ff;

   // Result register.
   logic       rsp_valid_ff, rsp_pen_ff, rsp_last_ff;
   logic [1:0] rsp_kind_ff;
   logic [5:0] rsp_x_ff, rsp_y_ff;

   logic [8:0]         vx, vy, px9, py9;
   logic               in_x, in_y;
   logic [COORD_W-1:0] nx, ny, x0, y0, dx, dy;
   logic [COORD_W:0]   rem_sh;
   logic               ge;
   logic signed [ACC_W-1:0] q_ext, slope_v, minor_ext;
   logic [AW-1:0]      plot_addr, first_addr;
   logic               emit;

   // Pad mapping: cell = (raw - 16) >> 1 inside the pad.
   always_comb begin
      vx   = {1'b0, tx_ff} - 9'(PAD_ORIGIN);
      vy   = {1'b0, ty_ff} - 9'(PAD_ORIGIN);
      in_x = (tx_ff >= 8'(PAD_ORIGIN)) && (vx < 9'(2 * COLS));
      in_y = (ty_ff >= 8'(PAD_ORIGIN)) && (vy < 9'(2 * ROWS));
      nx   = vx[COORD_W:1];
      ny   = vy[COORD_W:1];
   end

   always_comb begin
      x0 = last_col_ff;
      y0 = last_row_ff;
      dx = (nx >= x0) ? nx - x0 : x0 - nx;
      dy = (ny >= y0) ? ny - y0 : y0 - ny;
   end

   // One restoring division step per cycle.
   always_comb begin
      rem_sh = {rem_ff[COORD_W-1:0], num_ff[QUO_W-1]};
      ge     = rem_sh >= {1'b0, den_ff};
   end

   always_comb begin
      q_ext     = ACC_W'($signed({3'b000, quo_ff}));
      slope_v   = slope_neg_ff ? -q_ext : q_ext;
      minor_ext = $signed({3'b000, minor0_ff, {FRAC_BITS{1'b0}}});
   end

   // Cell on the current DDA step.
   always_comb begin
      px9        = xmaj_ff ? {2'b00, c_ff} : acc_ff[ACC_W-2:FRAC_BITS];
      py9        = xmaj_ff ? acc_ff[ACC_W-2:FRAC_BITS] : {2'b00, c_ff};
      plot_addr  = AW'(px9[COORD_W-1:0] * ROWS + py9[COORD_W-1:0]);
      first_addr = AW'(nx * ROWS + ny);
   end

   assign emit = cmd.paint_first | cmd.paint_line | cmd.emit_end | cmd.emit_pen;

   always_comb begin
      status.clr_done  = clr_ff == AW'(DEPTH - 1);
      status.is_btn    = cmd_ff == CMD_BUTTON;
      status.toggle    = press_ff && (pen_ff != button_ff);
      status.in_pad    = touched_ff && in_x && in_y;
      status.stroke    = stroke_ff;
      status.same_cell = (nx == x0) && (ny == y0);
      status.div_done  = div_cnt_ff == DIV_CNT_W'(QUO_W);
      status.at_end    = c_ff == c_end_ff;
      status.plot_ok   = !acc_ff[ACC_W-1] && (px9 < 9'(COLS)) && (py9 < 9'(ROWS));
      status.differs   = ram_rd_data != pen_ff;
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      ram_rd_en   = cmd.rd_first | cmd.rd_line;
      ram_rd_addr = cmd.rd_line ? plot_addr : first_addr;
      ram_wr_en   = cmd.clr_step | cmd.paint_first | cmd.paint_line;
      ram_wr_addr = cmd.clr_step ? clr_ff : addr_ff;
      ram_wr_data = cmd.clr_step ? 1'b0 : pen_ff;
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff     <= req_cmd;
         touched_ff <= req_touched;
         tx_ff      <= req_touch_x;
         ty_ff      <= req_touch_y;
         button_ff  <= req_button;
         press_ff   <= req_press;
      end
      if (cmd.line_init) begin
         xmaj_ff    <= dx > dy;
         num_ff     <= {((dx > dy) ? dy : dx), {FRAC_BITS{1'b0}}};
         rem_ff     <= '0;
         quo_ff     <= '0;
         div_cnt_ff <= '0;
         if (dx > dy) begin
            den_ff       <= dx;
            slope_neg_ff <= ny < y0;
            step_neg_ff  <= nx < x0;
            c_ff         <= x0;
            c_end_ff     <= nx;
            minor0_ff    <= y0;
         end else begin
            den_ff       <= dy;
            slope_neg_ff <= nx < x0;
            step_neg_ff  <= ny < y0;
            c_ff         <= y0;
            c_end_ff     <= ny;
            minor0_ff    <= x0;
         end
      end
      if (cmd.div_step) begin
         rem_ff     <= ge ? rem_sh - {1'b0, den_ff} : rem_sh;
         quo_ff     <= {quo_ff[QUO_W-2:0], ge};
         num_ff     <= {num_ff[QUO_W-2:0], 1'b0};
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
      if (cmd.line_start) begin
         acc_ff   <= minor_ext + slope_v;
         slope_ff <= slope_v;
         c_ff     <= step_neg_ff ? c_ff - 1'b1 : c_ff + 1'b1;
      end
      if (cmd.advance) begin
         acc_ff <= acc_ff + slope_ff;
         c_ff   <= step_neg_ff ? c_ff - 1'b1 : c_ff + 1'b1;
      end
      if (cmd.rd_first) begin
         addr_ff <= first_addr;
         px_ff   <= nx;
         py_ff   <= ny;
      end
      if (cmd.rd_line) begin
         addr_ff <= plot_addr;
         px_ff   <= px9[COORD_W-1:0];
         py_ff   <= py9[COORD_W-1:0];
      end
      if (emit) begin
         rsp_kind_ff <= cmd.emit_pen ? KIND_PEN : (cmd.emit_end ? KIND_END : KIND_PAINT);
         rsp_pen_ff  <= cmd.emit_pen ? ~pen_ff : pen_ff;
         rsp_last_ff <= ~cmd.paint_line;
         if (cmd.emit_pen) begin
            rsp_x_ff <= '0;
            rsp_y_ff <= '0;
         end else if (cmd.emit_end) begin
            rsp_x_ff <= last_col_ff[5:0];
            rsp_y_ff <= last_row_ff[5:0];
         end else begin
            rsp_x_ff <= px_ff[5:0];
            rsp_y_ff <= py_ff[5:0];
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff       <= 1'b1;
         stroke_ff    <= 1'b0;
         last_col_ff  <= '0;
         last_row_ff  <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.stroke_clr) begin
            stroke_ff <= 1'b0;
         end
         if (cmd.line_init) begin
            last_col_ff <= nx;
            last_row_ff <= ny;
         end
         if (cmd.paint_first) begin
            stroke_ff   <= 1'b1;
            last_col_ff <= px_ff;
            last_row_ff <= py_ff;
         end
         if (cmd.emit_pen) begin
            pen_ff <= ~pen_ff;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_cell_x      = rsp_x_ff;
   assign rsp_cell_y      = rsp_y_ff;
   assign rsp_pen_value   = rsp_pen_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule

FILE: design/tclp_ctrl.sv
// Controller state machine of the line plotter: sequences clearing, decoding,
// division and the cell walk. Depends on tclp_pkg.
module tclp_ctrl import tclp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_PEN,
      S_FIRST_RD,
      S_FIRST_CHK,
      S_DIV,
      S_LINE_TOP,
      S_LINE_CHK,
      S_END
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = state_ff == S_IDLE;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (status.is_btn) begin
               state_in = status.toggle ? S_PEN : S_IDLE;
            end else if (status.stroke) begin
               if (!status.in_pad) begin
                  cmd.stroke_clr = 1'b1;
                  state_in       = S_IDLE;
               end else begin
                  cmd.line_init = 1'b1;
                  state_in      = status.same_cell ? S_IDLE : S_DIV;
               end
            end else begin
               state_in = status.in_pad ? S_FIRST_RD : S_IDLE;
            end
         end
         S_PEN: begin
            if (status.out_free) begin
               cmd.emit_pen = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_FIRST_RD: begin
            cmd.rd_first = 1'b1;
            state_in     = S_FIRST_CHK;
         end
         S_FIRST_CHK: begin
            if (!status.differs) begin
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.paint_first = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               cmd.line_start = 1'b1;
               state_in       = S_LINE_TOP;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_LINE_TOP: begin
            if (status.at_end) begin
               state_in = S_END;
            end else if (status.plot_ok) begin
               cmd.rd_line = 1'b1;
               state_in    = S_LINE_CHK;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         S_LINE_CHK: begin
            if (!status.differs) begin
               cmd.advance = 1'b1;
               state_in    = S_LINE_TOP;
            end else if (status.out_free) begin
               cmd.paint_line = 1'b1;
               cmd.advance    = 1'b1;
               state_in       = S_LINE_TOP;
            end
         end
         S_END: begin
            if (status.out_free) begin
               cmd.emit_end = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/touch_canvas_line_plotter_unit.sv
// Touch canvas line plotter. After reset the block sweeps the canvas memory
// to zero, one cell per cycle, and accepts no beat during that sweep. It
// then takes one request beat at a time. A touch beat that starts a stroke
// does one canvas read and, when the cell differs, one write. A touch beat
// that continues a stroke runs a bit-serial division of 19 steps for the
// slope, then walks the major axis cell by cell (a cell read, then the check
// and, when the cell changes, the write). The canvas lives in one
// single-port-write RAM with registered read. Results leave through a
// registered rsp channel; the walk stalls while a result beat waits to be
// taken. Each request yields zero or more result beats, the final one flagged
// by rsp_last_result.
// Depends on tclp_pkg, tclp_ctrl, tclp_datapath and tclp_ram.
module touch_canvas_line_plotter_unit import tclp_pkg::*; #(
   parameter int COLS = DEF_COLS,
   parameter int ROWS = DEF_ROWS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_cmd,
   input  logic       req_touched,
   input  logic [7:0] req_touch_x,
   input  logic [7:0] req_touch_y,
   input  logic       req_button,
   input  logic       req_press,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [5:0] rsp_cell_x,
   output logic [5:0] rsp_cell_y,
   output logic       rsp_pen_value,
   output logic       rsp_last_result
);

   // Canvas memory is indexed column-major: address = column*ROWS + row.
   localparam int DEPTH = COLS * ROWS;
   localparam int AW    = $clog2(DEPTH);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   logic          ram_wr_en, ram_wr_data, ram_rd_en, ram_rd_data;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;

   tclp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tclp_datapath #(
      .COLS (COLS),
      .ROWS (ROWS),
      .AW   (AW)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_cmd),
      .req_touched     (req_touched),
      .req_touch_x     (req_touch_x),
      .req_touch_y     (req_touch_y),
      .req_button      (req_button),
      .req_press       (req_press),
      .cmd             (cmd),
      .status          (status),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_en       (ram_rd_en),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_cell_x      (rsp_cell_x),
      .rsp_cell_y      (rsp_cell_y),
      .rsp_pen_value   (rsp_pen_value),
      .rsp_last_result (rsp_last_result)
   );

   tclp_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_canvas (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

FILE: design/tclp_checker.sv
// Port-level checker of the line plotter, bound to the top level.
// Depends on tclp_pkg and touch_canvas_line_plotter_unit_macros.svh.
`include "touch_canvas_line_plotter_unit_macros.svh"

module tclp_checker import tclp_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [5:0] rsp_cell_x,
   input logic [5:0] rsp_cell_y,
   input logic       rsp_pen_value,
   input logic       rsp_last_result
);

   `TCLP_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid && !req_ready, "ports not quiet after reset")
   `TCLP_ASSERT(a_kind_legal, rsp_valid |-> rsp_kind != 2'd3, "illegal result kind")
   `TCLP_ASSERT(a_pen_beat, rsp_valid && rsp_kind == KIND_PEN |-> rsp_cell_x == 6'd0 && rsp_cell_y == 6'd0 && rsp_last_result, "malformed pen beat")
   `TCLP_ASSERT(a_end_last, rsp_valid && rsp_kind == KIND_END |-> rsp_last_result, "endpoint beat not last")
   `TCLP_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_cell_x) && $stable(rsp_cell_y) && $stable(rsp_pen_value) && $stable(rsp_last_result), "stalled beat changed")

endmodule

bind touch_canvas_line_plotter_unit tclp_checker u_checker (.*);
